[rtl/aimd_pkg.sv]
// ----------------------------------------------------------------------------
// AIMD congestion window package
// Window format, adder widths, register indexes, sequencer states and
// datapath operations shared by the block's modules.
// ----------------------------------------------------------------------------
package aimd_pkg;

    localparam int WIN_WHOLE_BITS = 16;
    localparam int WIN_FRAC_BITS  = 16;
    localparam int WIN_BITS       = WIN_WHOLE_BITS + WIN_FRAC_BITS;

    localparam int QUO_BITS  = 2 * WIN_FRAC_BITS;
    localparam int MUL_STEPS = 16;
    localparam int MUL_BITS  = WIN_BITS + MUL_STEPS;
    localparam int ADD_W0    = (MUL_BITS > QUO_BITS + 1) ? MUL_BITS : QUO_BITS + 1;
    localparam int ADD_BITS  = (ADD_W0 > 33) ? ADD_W0 : 33;
    localparam int CNT_BITS  = $clog2(QUO_BITS);

    localparam int FLOOR_W0   = (16 + WIN_FRAC_BITS > WIN_BITS) ? 16 + WIN_FRAC_BITS : WIN_BITS;
    localparam int FLOOR_BITS = FLOOR_W0 + 1;

    localparam logic [1:0] CFG_INCREASE_STEP   = 2'd0;
    localparam logic [1:0] CFG_DECREASE_FACTOR = 2'd1;
    localparam logic [1:0] CFG_RTT_LIMIT       = 2'd2;
    localparam logic [1:0] CFG_MIN_WINDOW      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RTT,
        S_CMP,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FLOOR,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RTT,
        OP_CMP,
        OP_DIV,
        OP_MUL,
        OP_ADD,
        OP_FLOOR,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        logic [15:0] step;
        logic [15:0] factor;
        logic [31:0] limit;
        logic [15:0] min_window;
    } t_cfg;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic carry;
        logic slow;
        logic out_free;
    } t_stat;

endpackage

[rtl/aimd_ctrl.sv]
// ----------------------------------------------------------------------------
// AIMD sequencer
// Steps one acknowledgement through the shared adder: round trip, compare, then
// divide and add, multiply and floor, or add; then hands the result to output.
// ----------------------------------------------------------------------------
module aimd_ctrl
    import aimd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RTT;
            end
            S_RTT: n_state = S_CMP;
            S_CMP: begin
                if (!i_stat.carry) begin
                    n_state = S_MUL;
                    n_cnt   = CNT_BITS'(MUL_STEPS - 1);
                end else if (i_stat.slow) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_DIV;
                    n_cnt   = CNT_BITS'(QUO_BITS - 1);
                end
            end
            S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_ADD;
            end
            S_MUL: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_FLOOR;
            end
            S_ADD:   n_state = S_OUT;
            S_FLOOR: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_ctrl.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) o_ctrl.op = OP_LOAD;
            end
            S_RTT:   o_ctrl.op = OP_RTT;
            S_CMP:   o_ctrl.op = OP_CMP;
            S_DIV:   o_ctrl.op = OP_DIV;
            S_MUL:   o_ctrl.op = OP_MUL;
            S_ADD:   o_ctrl.op = OP_ADD;
            S_FLOOR: o_ctrl.op = OP_FLOOR;
            S_OUT: begin
                if (i_stat.out_free) o_ctrl.op = OP_PUBLISH;
            end
            default: o_ctrl.op = OP_NONE;
        endcase
    end

endmodule

[rtl/aimd_dp.sv]
// ----------------------------------------------------------------------------
// AIMD datapath
// Window and slow start state, one shared add/subtract unit used for the
// round trip, the limit compare, restoring divide, shift-add multiply,
// growth with saturation and the floor compare; output register.
// ----------------------------------------------------------------------------
module aimd_dp
    import aimd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  t_cfg        i_cfg,
    input  logic [31:0] i_sent_time,
    input  logic [31:0] i_ack_time,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [15:0] o_window_whole,
    output logic [15:0] o_window_fraction,
    output logic        o_in_slow_start,
    output logic        o_congestion_seen
);

    logic [31:0]          r_sent, r_ack, r_rtt;
    logic [ADD_BITS-1:0]  r_acc;
    logic [QUO_BITS-1:0]  r_quo;
    logic [15:0]          r_mulb;
    logic [WIN_BITS-1:0]  r_window;
    logic                 r_slow, r_cong;
    logic                 r_out_valid;
    logic [15:0]          r_whole, r_frac;
    logic                 r_out_slow, r_out_cong;

    logic [ADD_BITS-1:0]   add_a, add_b;
    logic                  add_sub;
    logic [ADD_BITS:0]     add_sum;
    logic                  carry;

    logic [15+WIN_FRAC_BITS:0]   step_ext;
    logic [WIN_FRAC_BITS-1:0]    step_al;
    logic [FLOOR_BITS-1:0]       floor_ext;
    logic [WIN_BITS-1:0]         floor_w;
    logic [WIN_BITS-1:0]         divisor;
    logic [WIN_BITS-1:0]         dec_w;
    logic [WIN_BITS:0]           rem_sh;
    logic [WIN_WHOLE_BITS+15:0]  whole_ext;
    logic [WIN_FRAC_BITS+15:0]   frac_ext;
    logic                        out_free;

    assign step_ext  = {i_cfg.step, {WIN_FRAC_BITS{1'b0}}} >> 16;
    assign step_al   = step_ext[WIN_FRAC_BITS-1:0];
    assign floor_ext = FLOOR_BITS'({i_cfg.min_window, {WIN_FRAC_BITS{1'b0}}});
    assign floor_w   = (|floor_ext[FLOOR_BITS-1:WIN_BITS]) ? '1 : floor_ext[WIN_BITS-1:0];
    assign divisor   = (r_window == '0) ? WIN_BITS'(1) : r_window;
    assign dec_w     = r_acc[WIN_BITS+MUL_STEPS-1:MUL_STEPS];
    assign rem_sh    = {r_acc[WIN_BITS-1:0], r_quo[QUO_BITS-1]};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (i_ctrl.op)
            OP_RTT: begin
                add_a   = ADD_BITS'(r_ack);
                add_b   = ADD_BITS'(r_sent);
                add_sub = 1'b1;
            end
            OP_CMP: begin
                add_a   = ADD_BITS'(i_cfg.limit);
                add_b   = ADD_BITS'(r_rtt);
                add_sub = 1'b1;
            end
            OP_DIV: begin
                add_a   = ADD_BITS'(rem_sh);
                add_b   = ADD_BITS'(divisor);
                add_sub = 1'b1;
            end
            OP_MUL: begin
                add_a = r_acc << 1;
                add_b = r_mulb[15] ? ADD_BITS'(r_window) : '0;
            end
            OP_ADD: begin
                add_a = ADD_BITS'(r_window);
                add_b = r_slow ? ADD_BITS'(step_al) : ADD_BITS'(r_quo);
            end
            OP_FLOOR: begin
                add_a   = ADD_BITS'(dec_w);
                add_b   = ADD_BITS'(floor_w);
                add_sub = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {ADD_BITS{add_sub}}}
                   + (ADD_BITS+1)'(add_sub);
    assign carry   = add_sum[ADD_BITS];

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                r_sent <= i_sent_time;
                r_ack  <= i_ack_time;
            end
            OP_RTT: r_rtt <= add_sum[31:0];
            OP_CMP: begin
                r_cong <= !carry;
                r_acc  <= '0;
                r_quo  <= {step_al, {WIN_FRAC_BITS{1'b0}}};
                r_mulb <= i_cfg.factor;
            end
            OP_DIV: begin
                r_acc <= carry ? ADD_BITS'(add_sum[WIN_BITS-1:0])
                               : ADD_BITS'(rem_sh[WIN_BITS-1:0]);
                r_quo <= {r_quo[QUO_BITS-2:0], carry};
            end
            OP_MUL: begin
                r_acc  <= add_sum[ADD_BITS-1:0];
                r_mulb <= {r_mulb[14:0], 1'b0};
            end
            OP_PUBLISH: begin
                r_whole    <= (|whole_ext[WIN_WHOLE_BITS+15:16]) ? 16'hFFFF : whole_ext[15:0];
                r_frac     <= frac_ext[15:0];
                r_out_slow <= r_slow;
                r_out_cong <= r_cong;
            end
            default: r_rtt <= r_rtt;
        endcase
    end

    assign whole_ext = {16'b0, r_window[WIN_BITS-1:WIN_FRAC_BITS]};
    assign frac_ext  = {r_window[WIN_FRAC_BITS-1:0], 16'b0} >> WIN_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WIN_BITS'(16) << WIN_FRAC_BITS;
            r_slow      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctrl.op)
                OP_ADD: begin
                    r_window <= (|add_sum[ADD_BITS:WIN_BITS]) ? '1 : add_sum[WIN_BITS-1:0];
                end
                OP_FLOOR: begin
                    r_window <= carry ? dec_w : floor_w;
                    r_slow   <= 1'b0;
                end
                default: r_window <= r_window;
            endcase
            if (i_ctrl.op == OP_PUBLISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.carry    = carry;
    assign o_stat.slow     = r_slow;
    assign o_stat.out_free = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_window_whole    = r_whole;
    assign o_window_fraction = r_frac;
    assign o_in_slow_start   = r_out_slow;
    assign o_congestion_seen = r_out_cong;

endmodule

[rtl/aimd_congestion_window_top.sv]
// Result path, input transfer to result valid: round trip, limit compare, then
// growth add in slow start, 16-step shift-add multiply and floor compare on
// congestion, or restoring divide (one quotient bit per cycle in the shared
// adder) and growth add in congestion avoidance. One acknowledgement at a time:
// the next is taken in the cycle after the result enters the output register.
// Reset: synchronous; window 16.0, slow start on, registers at their defaults.
// ----------------------------------------------------------------------------
// AIMD congestion window top level
// Configuration registers, sequencer and shared-adder datapath.
// ----------------------------------------------------------------------------
module aimd_congestion_window_top
    import aimd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_sent_time,
    input  logic [31:0] i_ack_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_window_whole,
    output logic [15:0] o_window_fraction,
    output logic        o_in_slow_start,
    output logic        o_congestion_seen
);

    t_cfg  r_cfg;
    t_ctrl ctrl;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step       <= 16'd16384;
            r_cfg.factor     <= 16'd8192;
            r_cfg.limit      <= 32'd1000;
            r_cfg.min_window <= 16'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INCREASE_STEP:   r_cfg.step       <= i_cfg_data[15:0];
                CFG_DECREASE_FACTOR: r_cfg.factor     <= i_cfg_data[15:0];
                CFG_RTT_LIMIT:       r_cfg.limit      <= i_cfg_data;
                CFG_MIN_WINDOW:      r_cfg.min_window <= i_cfg_data[15:0];
                default:             r_cfg            <= r_cfg;
            endcase
        end
    end

    aimd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    aimd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_cfg             (r_cfg),
        .i_sent_time       (i_sent_time),
        .i_ack_time        (i_ack_time),
        .i_out_ready       (i_out_ready),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_window_whole    (o_window_whole),
        .o_window_fraction (o_window_fraction),
        .o_in_slow_start   (o_in_slow_start),
        .o_congestion_seen (o_congestion_seen)
    );

endmodule
